FILE: rtl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Types and constants shared by the Huffman tree decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

	localparam int NODE_COUNT  = 512;
	localparam int CODE_BITS   = 16;
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int USED_W      = $clog2(NODE_COUNT + 1);
	localparam int LEN_W       = $clog2(CODE_BITS + 1);
	localparam int MAX_RESULTS = 8;
	localparam int RES_W       = $clog2(MAX_RESULTS);
	localparam int CNT_W       = 4;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_DECODE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]           op;
		logic [7:0]           symbol;
		logic [CODE_BITS-1:0] code;
		logic [7:0]           data_byte;
		logic [CNT_W-1:0]     bit_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0] symbol_out;
		logic       last;
		logic       error;
	} out_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic [7:0]        sym;
		logic              leaf;
	} node_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_INS_STEP,
		ST_INS_LOAD,
		ST_DEC_START,
		ST_DEC_LOADW,
		ST_DEC_BIT,
		ST_DEC_LEAF,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/huffman_tree_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder_top
// Huffman code tree builder and decoder over a single-port node memory.
//
//   channel   direction   handshake               payload
//   in        sink        in_valid / in_ready     in_item  (in_item_t)
//   out       source      out_valid / out_ready   out_item (out_item_t)
//
// Every item is taken in the idle state; clear needs nothing more.
// Insert: find the leading one, step down the path allocating each new node
// or loading each existing one, mark the leaf; a full store sends an error.
// Decode: fetch the walk node, take each bit in turn (one node memory read
// for each bit whose child exists), close the walk, then send the results.
// Reset clears the root, node count and walk position; the memory itself is
// not swept. in_ready is low while an item is in work or its results wait.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_top import htd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	state_t state_q, state_d;

	// control state
	logic [USED_W-1:0] nodes_used_q;
	logic [NODE_W-1:0] walk_q;
	logic [NODE_W-1:0] root_left_q;
	logic [NODE_W-1:0] root_right_q;

	// working registers
	node_t                cur_q;
	logic [NODE_W-1:0]    cur_idx_q;
	logic [NODE_W-1:0]    child_q;
	logic [CODE_BITS-1:0] code_q;
	logic [LEN_W-1:0]     len_q;
	logic [7:0]           symbol_q;
	logic [7:0]           data_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     n_q;
	logic [RES_W-1:0]     out_idx_q;
	logic [7:0]           res_sym_q [MAX_RESULTS];
	logic                 res_err_q [MAX_RESULTS];

	// node memory
	node_t             mem [NODE_COUNT];
	node_t             rdata_q;
	logic              mem_we;
	logic              mem_re;
	logic [NODE_W-1:0] mem_waddr;
	logic [NODE_W-1:0] mem_raddr;
	node_t             mem_wdata;

	logic              in_acc;
	logic              out_acc;
	logic              ins_right;
	logic [NODE_W-1:0] ins_child;
	logic              store_full;
	logic [NODE_W-1:0] new_idx;
	logic [CNT_W-1:0]  cnt_dec;
	logic              dec_bit;
	logic [NODE_W-1:0] dec_child;
	logic              out_last;
	node_t             root_node;
	node_t             parent_upd;

	assign in_acc     = in_valid && in_ready;
	assign out_acc    = out_valid && out_ready;
	assign ins_right  = code_q[CODE_BITS-1];
	assign ins_child  = ins_right ? cur_q.right : cur_q.left;
	assign store_full = (nodes_used_q == USED_W'(NODE_COUNT));
	assign new_idx    = nodes_used_q[NODE_W-1:0];
	assign cnt_dec    = cnt_q - CNT_W'(1);
	assign dec_bit    = data_q[cnt_dec[2:0]];
	assign dec_child  = dec_bit ? cur_q.right : cur_q.left;
	assign out_last   = ({1'b0, out_idx_q} == n_q - CNT_W'(1));

	always_comb begin
		root_node       = '0;
		root_node.left  = root_left_q;
		root_node.right = root_right_q;
	end

	// parent with its missing child pointed at the node being allocated
	always_comb begin
		parent_upd = cur_q;
		if (ins_right) begin
			parent_upd.right = new_idx;
		end else begin
			parent_upd.left = new_idx;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (op_t'(in_item.op))
						OP_INSERT: state_d = ST_INS_SCAN;
						OP_DECODE: state_d = ST_DEC_START;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_INS_SCAN: begin
				if (ins_right || len_q <= LEN_W'(1)) begin
					state_d = ST_INS_STEP;
				end
			end
			ST_INS_STEP: begin
				if (len_q == '0) begin
					state_d = ST_IDLE;
				end else if (ins_child != '0) begin
					state_d = ST_INS_LOAD;
				end else if (store_full) begin
					state_d = ST_OUT;
				end
			end
			ST_INS_LOAD: state_d = ST_INS_STEP;
			ST_DEC_START: begin
				state_d = (walk_q == '0) ? ST_DEC_BIT : ST_DEC_LOADW;
			end
			ST_DEC_LOADW: state_d = ST_DEC_BIT;
			ST_DEC_BIT: begin
				if (cnt_q == '0) begin
					state_d = (n_q == '0) ? ST_IDLE : ST_OUT;
				end else if (dec_child != '0) begin
					state_d = ST_DEC_LEAF;
				end
			end
			ST_DEC_LEAF: state_d = ST_DEC_BIT;
			ST_OUT: begin
				if (out_acc && out_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = cur_idx_q;
		mem_raddr = walk_q;
		mem_wdata = cur_q;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_INS_STEP: begin
				if (len_q == '0) begin
					mem_we         = 1'b1;
					mem_wdata.sym  = symbol_q;
					mem_wdata.leaf = 1'b1;
				end else if (ins_child != '0) begin
					mem_re    = 1'b1;
					mem_raddr = ins_child;
				end else begin
					// on a full store the current node is flushed as it stands
					mem_we    = (cur_idx_q != '0);
					mem_wdata = store_full ? cur_q : parent_upd;
				end
			end
			ST_DEC_START: mem_re = (walk_q != '0);
			ST_DEC_BIT: begin
				if (cnt_q != '0 && dec_child != '0) begin
					mem_re    = 1'b1;
					mem_raddr = dec_child;
				end
			end
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		out_item.symbol_out = res_sym_q[out_idx_q];
		out_item.error      = res_err_q[out_idx_q];
		out_item.last       = out_last;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nodes_used_q <= USED_W'(1);
			walk_q       <= '0;
			root_left_q  <= '0;
			root_right_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && op_t'(in_item.op) == OP_CLEAR) begin
						nodes_used_q <= USED_W'(1);
						walk_q       <= '0;
						root_left_q  <= '0;
						root_right_q <= '0;
					end
				end
				ST_INS_STEP: begin
					if (len_q != '0 && ins_child == '0) begin
						if (store_full) begin
							walk_q <= '0;
						end else begin
							nodes_used_q <= nodes_used_q + USED_W'(1);
							if (cur_idx_q == '0) begin
								root_left_q  <= parent_upd.left;
								root_right_q <= parent_upd.right;
							end
						end
					end
				end
				ST_DEC_BIT: begin
					if (cnt_q != '0 && dec_child == '0) begin
						walk_q <= '0;
					end
				end
				ST_DEC_LEAF: begin
					walk_q <= rdata_q.leaf ? '0 : child_q;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					code_q    <= in_item.code;
					len_q     <= LEN_W'(CODE_BITS);
					symbol_q  <= in_item.symbol;
					data_q    <= in_item.data_byte;
					cnt_q     <= (in_item.bit_count > CNT_W'(8)) ? CNT_W'(8)
						: in_item.bit_count;
					n_q       <= '0;
					out_idx_q <= '0;
					cur_q     <= root_node;
					cur_idx_q <= '0;
				end
			end
			ST_INS_SCAN: begin
				// drop leading zeros; an all-zero code ends as the one-bit path 0
				if (!ins_right && len_q > LEN_W'(1)) begin
					code_q <= code_q << 1;
					len_q  <= len_q - LEN_W'(1);
				end
			end
			ST_INS_STEP: begin
				if (len_q != '0) begin
					if (ins_child != '0) begin
						cur_idx_q <= ins_child;
						code_q    <= code_q << 1;
						len_q     <= len_q - LEN_W'(1);
					end else if (store_full) begin
						res_sym_q[0] <= '0;
						res_err_q[0] <= 1'b1;
						n_q          <= CNT_W'(1);
						out_idx_q    <= '0;
					end else begin
						cur_q     <= '0;
						cur_idx_q <= new_idx;
						code_q    <= code_q << 1;
						len_q     <= len_q - LEN_W'(1);
					end
				end
			end
			ST_INS_LOAD: cur_q <= rdata_q;
			ST_DEC_START: begin
				if (walk_q == '0) begin
					cur_q <= root_node;
				end
			end
			ST_DEC_LOADW: cur_q <= rdata_q;
			ST_DEC_BIT: begin
				if (cnt_q != '0) begin
					if (dec_child == '0) begin
						res_sym_q[n_q[RES_W-1:0]] <= '0;
						res_err_q[n_q[RES_W-1:0]] <= 1'b1;
						n_q   <= n_q + CNT_W'(1);
						cnt_q <= cnt_dec;
						cur_q <= root_node;
					end else begin
						child_q <= dec_child;
					end
				end
			end
			ST_DEC_LEAF: begin
				cnt_q <= cnt_dec;
				if (rdata_q.leaf) begin
					res_sym_q[n_q[RES_W-1:0]] <= rdata_q.sym;
					res_err_q[n_q[RES_W-1:0]] <= 1'b0;
					n_q   <= n_q + CNT_W'(1);
					cur_q <= root_node;
				end else begin
					cur_q <= rdata_q;
				end
			end
			ST_OUT: begin
				if (out_acc && !out_last) begin
					out_idx_q <= out_idx_q + RES_W'(1);
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_nodes_range: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_used_q != '0 && nodes_used_q <= USED_W'(NODE_COUNT))
		else $error("node count out of range");

	a_out_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (n_q != '0 && {1'b0, out_idx_q} < n_q))
		else $error("result beat index beyond stored results");

	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("node memory read and write in one cycle");

	a_leaf_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC_LEAF) |-> $past(mem_re))
		else $error("leaf check without a node read");

	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while results pending");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Huffman tree decoder. Builds code trees with
// insert beats, decodes random bytes through them and compares every output
// beat with a local model of the node table, node count and walk position.
// ----------------------------------------------------------------------------
module tb_top;
	import htd_pkg::*;

	localparam int ITEM_TARGET = 230;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 100;
	localparam int SHOW_MAX    = 10;

	// tree model plus the queue of symbol beats still owed by the block
	class symbol_scoreboard;
		bit [NODE_W-1:0] left_of[NODE_COUNT];
		bit [NODE_W-1:0] right_of[NODE_COUNT];
		bit [7:0]        sym_of[NODE_COUNT];
		bit              is_leaf[NODE_COUNT];
		int unsigned     nodes_used;
		bit [NODE_W-1:0] walk_at;
		out_item_t       owed_symbols[$];
		int              fails, shown;
		int              n_clear, n_insert, n_decode, n_full;
		int              n_sym_beats, n_err_beats;

		function new();
			empty_tree();
		endfunction

		function void empty_tree();
			left_of[0]  = '0;
			right_of[0] = '0;
			sym_of[0]   = '0;
			is_leaf[0]  = 1'b0;
			nodes_used  = 1;
			walk_at     = '0;
		endfunction

		// walk the code path from its leading one, growing nodes as needed
		function bit grow_path(logic [7:0] sym, logic [CODE_BITS-1:0] code);
			int top;
			int len;
			bit go_right;
			bit [NODE_W-1:0] cur;
			bit [NODE_W-1:0] child;
			top = -1;
			cur = '0;
			for (int k = CODE_BITS - 1; k >= 0; k--) begin
				if (code[k]) begin
					top = k;
					break;
				end
			end
			len = (top < 0) ? 1 : top + 1;
			for (int k = len - 1; k >= 0; k--) begin
				go_right = (top >= 0) && code[k];
				child = go_right ? right_of[cur] : left_of[cur];
				if (child == 0) begin
					if (nodes_used >= NODE_COUNT)
						return 1'b0;
					child = nodes_used[NODE_W-1:0];
					left_of[child]  = '0;
					right_of[child] = '0;
					sym_of[child]   = '0;
					is_leaf[child]  = 1'b0;
					nodes_used++;
					if (go_right)
						right_of[cur] = child;
					else
						left_of[cur] = child;
				end
				cur = child;
			end
			sym_of[cur]  = sym;
			is_leaf[cur] = 1'b1;
			return 1'b1;
		endfunction

		function void note_item(in_item_t it);
			out_item_t beats[$];
			out_item_t r;
			int cnt;
			bit [NODE_W-1:0] child;
			case (op_t'(it.op))
				OP_CLEAR: begin
					n_clear++;
					empty_tree();
				end
				OP_INSERT: begin
					n_insert++;
					if (!grow_path(it.symbol, it.code)) begin
						n_full++;
						walk_at = '0;
						r.symbol_out = '0;
						r.last = 1'b1;
						r.error = 1'b1;
						owed_symbols.push_back(r);
					end
				end
				OP_DECODE: begin
					n_decode++;
					cnt = (it.bit_count > 8) ? 8 : int'(it.bit_count);
					for (int b = cnt - 1; b >= 0; b--) begin
						child = it.data_byte[b] ? right_of[walk_at] : left_of[walk_at];
						r.last = 1'b0;
						if (child == 0) begin
							r.symbol_out = '0;
							r.error = 1'b1;
							beats.push_back(r);
							walk_at = '0;
						end else if (is_leaf[child]) begin
							r.symbol_out = sym_of[child];
							r.error = 1'b0;
							beats.push_back(r);
							walk_at = '0;
						end else begin
							walk_at = child;
						end
					end
					if (beats.size() > 0)
						beats[beats.size() - 1].last = 1'b1;
					foreach (beats[i])
						owed_symbols.push_back(beats[i]);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_beat(out_item_t got);
			out_item_t want;
			if (got.error)
				n_err_beats++;
			else
				n_sym_beats++;
			if (owed_symbols.size() == 0) begin
				fails++;
				if (shown < SHOW_MAX) begin
					shown++;
					$display("unexpected output beat: symbol %02h last %0d error %0d",
						got.symbol_out, got.last, got.error);
				end
				return;
			end
			want = owed_symbols.pop_front();
			if (got.symbol_out !== want.symbol_out || got.last !== want.last ||
					got.error !== want.error) begin
				fails++;
				if (shown < SHOW_MAX) begin
					shown++;
					$display("output mismatch: want symbol %02h last %0d error %0d",
						want.symbol_out, want.last, want.error);
					$display("                 got  symbol %02h last %0d error %0d",
						got.symbol_out, got.last, got.error);
				end
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	symbol_scoreboard sb;
	bit calm = 1'b0;
	int items_sent = 0;
	int cycles = 0;

	huffman_tree_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat(out_item);
		out_ready <= calm || ($urandom_range(0, 99) >= 23);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL huffman_tree_decoder_top");
			$finish;
		end
	end

	function automatic in_item_t rand_item();
		in_item_t it;
		it.op        = 2'($urandom_range(0, 3));
		it.symbol    = 8'($urandom);
		it.code      = CODE_BITS'($urandom);
		it.data_byte = 8'($urandom);
		it.bit_count = CNT_W'($urandom);
		return it;
	endfunction

	// called just after a rising edge; returns at the edge that takes the beat
	task automatic send_beat(input in_item_t it);
		while (!calm && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
		if (op_t'(it.op) != OP_NONE)
			items_sent++;
	endtask

	task automatic clear_op();
		in_item_t it;
		it = rand_item();
		it.op = OP_CLEAR;
		send_beat(it);
	endtask

	task automatic insert_op(input logic [7:0] sym, input logic [CODE_BITS-1:0] code);
		in_item_t it;
		it = rand_item();
		it.op = OP_INSERT;
		it.symbol = sym;
		it.code = code;
		send_beat(it);
	endtask

	task automatic decode_op(input logic [7:0] data, input logic [CNT_W-1:0] cnt);
		in_item_t it;
		it = rand_item();
		it.op = OP_DECODE;
		it.data_byte = data;
		it.bit_count = cnt;
		send_beat(it);
	endtask

	// idle the input and wait on the clock until nothing is owed, so the next beat is driven in a later step
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.owed_symbols.size() != 0);
	endtask

	initial begin
		int episode;
		int depth;
		int guard;
		int hits0;
		in_item_t it;

		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tree, three-symbol code, walks across beats,
		// extension below a leaf, overwrite, unused op, clear mid-walk
		decode_op(8'hA5, 4'd8);
		insert_op(8'h00, 16'h0000);
		insert_op(8'hFF, 16'h0002);
		insert_op(8'h5A, 16'h0003);
		decode_op(8'h00, 4'd8);
		decode_op(8'hFF, 4'd8);
		decode_op(8'hB4, 4'd8);
		decode_op(8'h55, 4'd0);
		decode_op(8'h3C, 4'd15);
		decode_op(8'h01, 4'd1);
		decode_op(8'h00, 4'd1);
		insert_op(8'h81, 16'hFFFF);
		insert_op(8'h7E, 16'h8000);
		insert_op(8'h33, 16'h0002);
		decode_op(8'hC3, 4'd8);
		it = rand_item();
		it.op = OP_NONE;
		send_beat(it);
		insert_op(8'h99, 16'h0001);
		decode_op(8'h6A, 4'd7);
		decode_op(8'h01, 4'd1);
		clear_op();
		insert_op(8'h44, 16'h0002);
		decode_op(8'h6C, 4'd8);
		decode_op(8'h01, 4'd1);
		clear_op();
		decode_op(8'h00, 4'd4);
		drain();

		episode = 0;
		while (items_sent < ITEM_TARGET) begin
			calm = (episode == 5 || episode == 6);
			if (episode == 3) begin
				// fill the node store with long paths until an insert runs out
				clear_op();
				hits0 = sb.n_full;
				guard = 0;
				while (sb.n_full == hits0 && guard < 80) begin
					insert_op(8'($urandom), CODE_BITS'($urandom | 32'h8000));
					guard++;
				end
				repeat (6) decode_op(8'($urandom), CNT_W'($urandom_range(1, 8)));
				insert_op(8'($urandom), CODE_BITS'($urandom_range(0, 255)));
				drain();
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						// complete prefix code: "0" plus a full subtree under "1"
						if ($urandom_range(0, 4) != 0)
							clear_op();
						insert_op(8'($urandom), 16'h0000);
						depth = $urandom_range(1, 4);
						for (int k = 0; k < (1 << depth); k++)
							insert_op(8'($urandom), CODE_BITS'((1 << depth) | k));
						repeat ($urandom_range(4, 12))
							decode_op(8'($urandom), ($urandom_range(0, 3) != 0) ? CNT_W'(8)
								: CNT_W'($urandom_range(1, 8)));
					end
					6, 7: begin
						repeat ($urandom_range(2, 6))
							insert_op(8'($urandom), CODE_BITS'($urandom_range(0, 63)));
						repeat ($urandom_range(3, 8))
							decode_op(8'($urandom), CNT_W'($urandom_range(1, 8)));
					end
					default: begin
						repeat ($urandom_range(4, 10))
							send_beat(rand_item());
					end
				endcase
				if ($urandom_range(0, 3) == 0)
					drain();
			end
			episode++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (sb.owed_symbols.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.owed_symbols.size() != 0) begin
			sb.fails++;
			$display("%0d expected beats never arrived", sb.owed_symbols.size());
		end

		$display("covered %0d clears, %0d inserts (%0d hit a full store), %0d decodes",
			sb.n_clear, sb.n_insert, sb.n_full, sb.n_decode);
		$display("checked %0d symbol beats and %0d error beats, %0d failures",
			sb.n_sym_beats, sb.n_err_beats, sb.fails);
		if (sb.fails == 0)
			$display("PASS huffman_tree_decoder_top");
		else
			$display("FAIL huffman_tree_decoder_top");
		$finish;
	end

endmodule
